[rtl/hop_sequence_generator_top_macros.svh]
// assertion macros of the hop sequence generator checker
`ifndef HOP_SEQUENCE_GENERATOR_TOP_MACROS_SVH
`define HOP_SEQUENCE_GENERATOR_TOP_MACROS_SVH

// clocked assertion, off while reset is asserted
`define HSG_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// clocked assertion that also watches the reset cycles
`define HSG_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/hsg_pkg.sv]
// types, constants, microcode and helper functions of the hop sequence generator
package hsg_pkg;

    localparam int OFFSET_W   = 8;
    localparam int SEED_W     = 8;
    localparam int CHAN_W     = 7;
    localparam int IDX_W      = 6;
    localparam int PC_W       = 4;
    localparam int NUM_HOPS_DEFAULT = 20;

    localparam logic [SEED_W-1:0] LFSR_TAPS         = 8'h60;
    localparam logic [CHAN_W-1:0] SEARCH_STEPS      = 7'd127;
    localparam logic [CHAN_W-1:0] MAX_CHANNEL_RESET = 7'd69;
    localparam logic [8:0]        CHAN_MOD          = 9'd127;
    localparam logic [8:0]        CHAN_MOD_X2       = 9'd254;

    // datapath actions of one microcode step
    typedef enum logic [2:0] {
        OP_NOP,
        OP_LOAD,
        OP_STEP,
        OP_CAND,
        OP_PUSH,
        OP_KEEP,
        OP_FLUSH,
        OP_BAD
    } t_op;

    // jump conditions
    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_REQ,
        C_BAD_SEED,
        C_REJECT,
        C_OUT_BUSY,
        C_MORE
    } t_cond;

    typedef struct packed {
        t_op              op;
        t_cond            cond;
        logic [PC_W-1:0]  target;
    } t_uword;

    // datapath flags seen by the sequencer
    typedef struct packed {
        logic req_valid;
        logic seed_bad;
        logic reject;
        logic out_busy;
        logic more;
    } t_status;

    // program addresses
    localparam logic [PC_W-1:0] A_IDLE    = 4'd0;
    localparam logic [PC_W-1:0] A_CHECK   = 4'd1;
    localparam logic [PC_W-1:0] A_STEP    = 4'd2;
    localparam logic [PC_W-1:0] A_CAND    = 4'd3;
    localparam logic [PC_W-1:0] A_TEST    = 4'd4;
    localparam logic [PC_W-1:0] A_PUSH    = 4'd5;
    localparam logic [PC_W-1:0] A_KEEP    = 4'd6;
    localparam logic [PC_W-1:0] A_LOOP    = 4'd7;
    localparam logic [PC_W-1:0] A_FLUSH   = 4'd8;
    localparam logic [PC_W-1:0] A_DONE    = 4'd9;
    localparam logic [PC_W-1:0] A_BAD     = 4'd10;
    localparam logic [PC_W-1:0] A_BADDONE = 4'd11;

    // control store: on a true condition jump to target, else fall through
    function automatic t_uword ucode(input logic [PC_W-1:0] pc);
        t_uword w;
        unique case (pc)
            A_IDLE:    w = '{op: OP_LOAD,  cond: C_NO_REQ,   target: A_IDLE};
            A_CHECK:   w = '{op: OP_NOP,   cond: C_BAD_SEED, target: A_BAD};
            A_STEP:    w = '{op: OP_STEP,  cond: C_NEVER,    target: A_IDLE};
            A_CAND:    w = '{op: OP_CAND,  cond: C_NEVER,    target: A_IDLE};
            A_TEST:    w = '{op: OP_NOP,   cond: C_REJECT,   target: A_LOOP};
            A_PUSH:    w = '{op: OP_PUSH,  cond: C_OUT_BUSY, target: A_PUSH};
            A_KEEP:    w = '{op: OP_KEEP,  cond: C_NEVER,    target: A_IDLE};
            A_LOOP:    w = '{op: OP_NOP,   cond: C_MORE,     target: A_STEP};
            A_FLUSH:   w = '{op: OP_FLUSH, cond: C_OUT_BUSY, target: A_FLUSH};
            A_DONE:    w = '{op: OP_NOP,   cond: C_ALWAYS,   target: A_IDLE};
            A_BAD:     w = '{op: OP_BAD,   cond: C_OUT_BUSY, target: A_BAD};
            A_BADDONE: w = '{op: OP_NOP,   cond: C_ALWAYS,   target: A_IDLE};
            default:   w = '{op: OP_NOP,   cond: C_ALWAYS,   target: A_IDLE};
        endcase
        return w;
    endfunction

    // one galois step of x^7+x^6+1, shifting right
    function automatic logic [SEED_W-1:0] lfsr_next(input logic [SEED_W-1:0] s);
        return {1'b0, s[SEED_W-1:1]} ^ (s[0] ? LFSR_TAPS : '0);
    endfunction

    // sum below 3*127+2 reduced mod 127 by two compare and subtract steps
    function automatic logic [CHAN_W-1:0] mod127(input logic [8:0] sum);
        logic [8:0] v;
        v = sum;
        if (v >= CHAN_MOD_X2) begin
            v = v - CHAN_MOD_X2;
        end
        if (v >= CHAN_MOD) begin
            v = v - CHAN_MOD;
        end
        return v[CHAN_W-1:0];
    endfunction

endpackage

[rtl/hsg_if.sv]
// handshake channels of the hop sequence generator
interface hsg_req_if import hsg_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [OFFSET_W-1:0] channel_offset;
    logic [SEED_W-1:0]   lfsr_seed;

    modport source (output valid, output channel_offset, output lfsr_seed, input ready);
    modport sink   (input valid, input channel_offset, input lfsr_seed, output ready);
endinterface

interface hsg_hop_if import hsg_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [IDX_W-1:0]  hop_index;
    logic [CHAN_W-1:0] channel;
    logic              last;
    logic              bad_seed;

    modport source (output valid, output hop_index, output channel, output last,
                    output bad_seed, input ready);
    modport sink   (input valid, input hop_index, input channel, input last,
                    input bad_seed, output ready);
endinterface

interface hsg_cfg_if import hsg_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/hop_sequence_generator_top.sv]
// Hop sequence generator, top level.
// A request on i_req (channel_offset, lfsr_seed) starts a search: a 7-bit
// galois lfsr (x^7+x^6+1) is stepped and each value plus the offset, mod 127,
// is a candidate channel. Candidates above max_channel are skipped; the lfsr
// never repeats within 127 steps, so no channel comes twice. Accepted channels
// leave on o_hop with hop_index counting from 0, last set on the final hop of
// the request. A zero seed, or one that clears the lfsr on its first step,
// gives one hop with bad_seed set.
// i_cfg writes max_channel (reset 69); it is always ready. The user must write
// it only while the block is idle; the block itself does not enforce this.
// A microcoded sequencer drives the datapath, one control word per cycle:
// it takes the request and checks the seed, then per step advances the lfsr,
// forms the candidate and tests it; an accepted one pushes the pending hop and
// keeps the candidate, and a flush word sends the final hop. At most 127 steps.
// A new request is taken only when the program is back at its idle word.
// When the receiver stalls, the finished hop waits in the output register and
// the search pauses at its next hand-over. Reset returns the program to idle,
// drops any pending hop and sets max_channel to 69.
module hop_sequence_generator_top import hsg_pkg::*; #(
    parameter int NUM_HOPS = NUM_HOPS_DEFAULT
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    hsg_req_if.sink   i_req,
    hsg_hop_if.source o_hop,
    hsg_cfg_if.sink   i_cfg
);

    logic [CHAN_W-1:0] r_max_channel;
    t_uword            uword;
    t_status           status;

    // configuration register
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_channel <= MAX_CHANNEL_RESET;
        end else if (i_cfg.valid) begin
            r_max_channel <= i_cfg.data;
        end
    end

    // control store and step counter
    hsg_sequencer u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_uword  (uword)
    );

    // datapath
    hsg_datapath #(
        .NUM_HOPS (NUM_HOPS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_op          (uword.op),
        .i_max_channel (r_max_channel),
        .i_req         (i_req),
        .o_hop         (o_hop),
        .o_status      (status)
    );

endmodule

[rtl/hsg_sequencer.sv]
// microcode step counter with conditional jumps
module hsg_sequencer import hsg_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_status i_status,
    output t_uword  o_uword
);

    logic [PC_W-1:0] r_pc;
    logic [PC_W-1:0] n_pc;
    t_uword          w;
    logic            take;

    assign w       = ucode(r_pc);
    assign o_uword = w;

    // jump condition
    always_comb begin
        unique case (w.cond)
            C_NEVER:    take = 1'b0;
            C_ALWAYS:   take = 1'b1;
            C_NO_REQ:   take = !i_status.req_valid;
            C_BAD_SEED: take = i_status.seed_bad;
            C_REJECT:   take = i_status.reject;
            C_OUT_BUSY: take = i_status.out_busy;
            C_MORE:     take = i_status.more;
            default:    take = 1'b1;
        endcase
        n_pc = take ? w.target : r_pc + 1'b1;
    end

    // step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= A_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

[rtl/hsg_datapath.sv]
// lfsr, candidate, pending hop and output register
module hsg_datapath import hsg_pkg::*; #(
    parameter int NUM_HOPS = NUM_HOPS_DEFAULT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_op               i_op,
    input  logic [CHAN_W-1:0] i_max_channel,
    hsg_req_if.sink           i_req,
    hsg_hop_if.source         o_hop,
    output t_status           o_status
);

    localparam int CNT_W = $clog2(NUM_HOPS + 1);

    logic [SEED_W-1:0]   r_s;
    logic [OFFSET_W-1:0] r_offset;
    logic [CHAN_W-1:0]   r_cand;
    logic [CHAN_W-1:0]   r_steps;
    logic [CNT_W-1:0]    r_count;
    logic [CHAN_W-1:0]   r_pend_ch;
    logic [IDX_W-1:0]    r_pend_idx;
    logic                r_pend_v;
    logic                r_out_valid;
    logic [IDX_W-1:0]    r_out_idx;
    logic [CHAN_W-1:0]   r_out_ch;
    logic                r_out_last;
    logic                r_out_bad;
    logic                load;

    assign load        = (i_op == OP_LOAD) && i_req.valid;
    assign i_req.ready = (i_op == OP_LOAD);

    assign o_hop.valid     = r_out_valid;
    assign o_hop.hop_index = r_out_idx;
    assign o_hop.channel   = r_out_ch;
    assign o_hop.last      = r_out_last;
    assign o_hop.bad_seed  = r_out_bad;

    // flags for the sequencer
    // x^7+x^6+1 is primitive: the 127 states after the first step are all
    // different and nonzero, one per residue mod 127, so no candidate repeats
    always_comb begin
        o_status.req_valid = i_req.valid;
        o_status.seed_bad  = (r_s == '0) || (lfsr_next(r_s) == '0);
        o_status.reject    = (r_cand > i_max_channel);
        o_status.out_busy  = r_out_valid;
        o_status.more      = (r_steps != SEARCH_STEPS) && (r_count < CNT_W'(NUM_HOPS));
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_v    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && o_hop.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (i_op)
                OP_LOAD: begin
                    if (load) begin
                        r_pend_v <= 1'b0;
                    end
                end
                OP_KEEP: r_pend_v <= 1'b1;
                OP_PUSH, OP_FLUSH: begin
                    if (!r_out_valid) begin
                        r_pend_v    <= 1'b0;
                        r_out_valid <= r_pend_v;
                    end
                end
                OP_BAD: begin
                    if (!r_out_valid) begin
                        r_out_valid <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        unique case (i_op)
            OP_LOAD: begin
                if (load) begin
                    r_s      <= i_req.lfsr_seed;
                    r_offset <= i_req.channel_offset;
                    r_steps  <= '0;
                    r_count  <= '0;
                end
            end
            OP_STEP: begin
                r_s     <= lfsr_next(r_s);
                r_steps <= r_steps + 1'b1;
            end
            OP_CAND: r_cand <= mod127({1'b0, r_s} + {1'b0, r_offset});
            OP_KEEP: begin
                r_pend_ch  <= r_cand;
                r_pend_idx <= IDX_W'(r_count);
                r_count    <= r_count + 1'b1;
            end
            OP_PUSH, OP_FLUSH: begin
                if (!r_out_valid) begin
                    r_out_idx  <= r_pend_idx;
                    r_out_ch   <= r_pend_ch;
                    r_out_last <= (i_op == OP_FLUSH);
                    r_out_bad  <= 1'b0;
                end
            end
            OP_BAD: begin
                if (!r_out_valid) begin
                    r_out_idx  <= '0;
                    r_out_ch   <= '0;
                    r_out_last <= 1'b1;
                    r_out_bad  <= 1'b1;
                end
            end
            default: ;
        endcase
    end

endmodule

[rtl/hsg_checker.sv]
// port level checks of the hop sequence generator and their binding
`include "hop_sequence_generator_top_macros.svh"

module hsg_checker import hsg_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_req_valid,
    input logic              i_req_ready,
    input logic              i_hop_valid,
    input logic              i_hop_ready,
    input logic [IDX_W-1:0]  i_hop_index,
    input logic [CHAN_W-1:0] i_channel,
    input logic              i_last,
    input logic              i_bad_seed
);

    logic                    hop_fire;
    logic                    hop_stall;
    logic                    req_fire;
    logic                    bad_hop;
    logic                    bad_shape;
    logic [IDX_W+CHAN_W+1:0] hop_data;

    // handshake and payload views
    assign hop_fire  = i_hop_valid && i_hop_ready;
    assign hop_stall = i_hop_valid && !i_hop_ready;
    assign req_fire  = i_req_valid && i_req_ready;
    assign bad_hop   = i_hop_valid && i_bad_seed;
    assign bad_shape = i_last && (i_channel == '0) && (i_hop_index == '0);
    assign hop_data  = {i_hop_index, i_channel, i_last, i_bad_seed};

    // no hop right after reset
    `HSG_ASSERT_RST(a_reset_quiet, i_clk, !i_rst_n |=> !i_hop_valid, "hop valid after reset")

    // a stalled hop holds
    `HSG_ASSERT(a_hold, i_clk, i_rst_n, hop_stall |=> i_hop_valid && $stable(hop_data), "hop not held")

    // a bad seed hop is the lone final hop on channel zero
    `HSG_ASSERT(a_bad_form, i_clk, i_rst_n, bad_hop |-> bad_shape, "malformed bad seed hop")

    // a non-final hop means the request is still running
    `HSG_ASSERT(a_no_overlap, i_clk, i_rst_n, hop_fire && !i_last |=> !req_fire, "request mid sequence")

endmodule

bind hop_sequence_generator_top hsg_checker u_hsg_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_hop_valid (o_hop.valid),
    .i_hop_ready (o_hop.ready),
    .i_hop_index (o_hop.hop_index),
    .i_channel   (o_hop.channel),
    .i_last      (o_hop.last),
    .i_bad_seed  (o_hop.bad_seed)
);

[verif/hop_sequence_generator_top_test.sv]
// self-checking testbench of the hop sequence generator: table, random requests, max_channel sweep
module hop_sequence_generator_top_test import hsg_pkg::*; ();

    localparam int NUM_HOPS      = 20;
    localparam int HOP_CAP       = 64;
    localparam int SEARCH_LEN    = 127;
    localparam int CHANNEL_COUNT = 127;
    localparam int RESET_CYCLES  = 12;
    localparam int SETTLE_CYCLES = 16;
    localparam int LONG_HOLD     = 600;
    localparam int HOLD_AFTER    = 250;
    localparam int LIMIT_CYCLES  = 3_000_000;
    localparam int NUM_PHASES    = 10;

    localparam logic [SEED_W-1:0] ZERO_SEED  = 8'h00;
    localparam logic [SEED_W-1:0] DEAD_SEED  = 8'hC1;
    localparam logic [SEED_W-1:0] GALOIS_TAP = 8'h60;
    localparam logic [CHAN_W-1:0] MAX_CH_RST = 7'd69;

    typedef struct packed {
        logic [IDX_W-1:0]  hop_index;
        logic [CHAN_W-1:0] channel;
        logic              last;
        logic              bad_seed;
    } t_hop_rec;

    // one request of the directed table, with a typed expectation where obvious
    typedef struct packed {
        logic [OFFSET_W-1:0] offset;
        logic [SEED_W-1:0]   seed;
        logic                typed;
        t_hop_rec            want;
    } t_req_row;

    localparam t_hop_rec BAD_HOP = '{hop_index: '0, channel: '0, last: 1'b1, bad_seed: 1'b1};
    localparam t_hop_rec NO_HOP  = '0;

    localparam int NUM_ROWS = 16;
    localparam t_req_row DIRECTED_ROWS [NUM_ROWS] = '{
        '{8'h00, ZERO_SEED, 1'b1, BAD_HOP},
        '{8'hFF, ZERO_SEED, 1'b1, BAD_HOP},
        '{8'h00, DEAD_SEED, 1'b1, BAD_HOP},
        '{8'hFF, DEAD_SEED, 1'b1, BAD_HOP},
        '{8'h00, 8'h01,     1'b0, NO_HOP},
        '{8'hFF, 8'hFF,     1'b0, NO_HOP},
        '{8'h00, 8'h80,     1'b0, NO_HOP},
        '{8'h7F, 8'h7F,     1'b0, NO_HOP},
        '{8'h7E, 8'h40,     1'b0, NO_HOP},
        '{8'h80, 8'h81,     1'b0, NO_HOP},
        '{8'h55, 8'hAA,     1'b0, NO_HOP},
        '{8'hAA, 8'h55,     1'b0, NO_HOP},
        '{8'h01, 8'hFE,     1'b0, NO_HOP},
        '{8'hFE, 8'h02,     1'b0, NO_HOP},
        '{8'hFF, 8'h01,     1'b0, NO_HOP},
        '{8'h00, 8'hFF,     1'b0, NO_HOP}
    };

    // max_channel per phase, the rest drawn at random
    localparam int NUM_FIXED = 6;
    localparam logic [CHAN_W-1:0] MAX_CH_PLAN [NUM_FIXED] = '{
        7'd63, 7'd126, 7'd127, 7'd0, 7'd9, 7'd69
    };

    logic i_clk;
    logic i_rst_n;

    hsg_req_if req_ch();
    hsg_hop_if hop_ch();
    hsg_cfg_if cfg_ch();

    hop_sequence_generator_top #(
        .NUM_HOPS(NUM_HOPS)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch),
        .o_hop  (hop_ch),
        .i_cfg  (cfg_ch)
    );

    t_hop_rec          expected_hops[$];
    logic [CHAN_W-1:0] max_channel_now;
    int                mismatches;
    int                hops_seen;
    int                cycles;
    logic              typed_pending;
    t_hop_rec          typed_hop;
    int                send_streak;
    bit                send_quiet;
    int                take_streak;
    bit                take_quiet;

    // clock
    initial begin
        i_clk = 1'b0;
    end
    always begin
        #6 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        cycles = 0;
        while (cycles < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("FAILURE");
        $finish;
    end

    // one galois step, x^7+x^6+1 shifting right
    function automatic logic [SEED_W-1:0] lfsr_advance(input logic [SEED_W-1:0] s);
        logic [SEED_W-1:0] shifted;
        shifted = s >> 1;
        if (s[0]) begin
            shifted = shifted ^ GALOIS_TAP;
        end
        return shifted;
    endfunction

    // expected hops of one request under the current max_channel
    function automatic void predict_hops(input logic [OFFSET_W-1:0] offset,
                                         input logic [SEED_W-1:0] seed);
        logic [SEED_W-1:0] state;
        logic [126:0]      taken;
        t_hop_rec          run[$];
        t_hop_rec          rec;
        int                chan;
        int                cap;
        cap = (NUM_HOPS > HOP_CAP) ? HOP_CAP : ((NUM_HOPS < 1) ? 1 : NUM_HOPS);
        if (seed == ZERO_SEED || lfsr_advance(seed) == ZERO_SEED) begin
            expected_hops.push_back(BAD_HOP);
            return;
        end
        state = seed;
        taken = '0;
        for (int n = 0; n < SEARCH_LEN && run.size() < cap; n++) begin
            state = lfsr_advance(state);
            chan = (int'(state) + int'(offset)) % CHANNEL_COUNT;
            if (chan <= int'(max_channel_now) && !taken[chan]) begin
                taken[chan]   = 1'b1;
                rec.hop_index = IDX_W'(run.size());
                rec.channel   = CHAN_W'(chan);
                rec.last      = 1'b0;
                rec.bad_seed  = 1'b0;
                run.push_back(rec);
            end
        end
        // final hop of the request carries last
        if (run.size() > 0) begin
            rec = run.pop_back();
            rec.last = 1'b1;
            run.push_back(rec);
        end
        foreach (run[k]) begin
            expected_hops.push_back(run[k]);
        end
    endfunction

    // wait for the next item: streaks of random gaps and, one time in four, back-to-back streaks
    function automatic int draw_gap(inout int streak, inout bit quiet);
        if (streak == 0) begin
            streak = $urandom_range(1, 40);
            quiet  = ($urandom_range(0, 3) == 0);
        end
        streak--;
        return quiet ? 0 : int'($urandom_range(0, 12));
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // request transfers feed the predictor, hop transfers are checked in order
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (req_ch.valid && req_ch.ready) begin
                if (typed_pending) begin
                    expected_hops.push_back(typed_hop);
                end else begin
                    predict_hops(req_ch.channel_offset, req_ch.lfsr_seed);
                end
            end
            if (hop_ch.valid && hop_ch.ready) begin
                hops_seen++;
                if (expected_hops.size() == 0) begin
                    $error("unexpected hop: index %0d channel %0d", hop_ch.hop_index,
                           hop_ch.channel);
                    mismatches++;
                end else begin
                    check_field("hop_index", expected_hops[0].hop_index, hop_ch.hop_index);
                    check_field("channel", expected_hops[0].channel, hop_ch.channel);
                    check_field("last", expected_hops[0].last, hop_ch.last);
                    check_field("bad_seed", expected_hops[0].bad_seed, hop_ch.bad_seed);
                    void'(expected_hops.pop_front());
                end
            end
        end
    end

    // hop receiver with random stalls and one long hold-off
    initial begin
        int  gap;
        bit  held;
        hop_ch.ready = 1'b0;
        held = 1'b0;
        forever begin
            gap = draw_gap(take_streak, take_quiet);
            if (!held && hops_seen >= HOLD_AFTER) begin
                gap  = LONG_HOLD;
                held = 1'b1;
            end
            @(negedge i_clk);
            if (gap > 0) begin
                hop_ch.ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            hop_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(hop_ch.valid && hop_ch.ready));
        end
    end

    task automatic send_request(input logic [OFFSET_W-1:0] offset,
                                input logic [SEED_W-1:0] seed,
                                input logic typed, input t_hop_rec want);
        int gap;
        gap = draw_gap(send_streak, send_quiet);
        @(negedge i_clk);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.valid          <= 1'b1;
        req_ch.channel_offset <= offset;
        req_ch.lfsr_seed      <= seed;
        typed_pending = typed;
        typed_hop     = want;
        do @(posedge i_clk); while (!(req_ch.valid && req_ch.ready));
    endtask

    // stop offering and let every expected hop arrive
    task automatic drain_hops();
        @(negedge i_clk);
        req_ch.valid <= 1'b0;
        while (expected_hops.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_max_channel(input logic [CHAN_W-1:0] value);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!(cfg_ch.valid && cfg_ch.ready));
        max_channel_now = value;
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // stimulus
    initial begin
        logic [CHAN_W-1:0]   max_ch;
        logic [OFFSET_W-1:0] offset;
        logic [SEED_W-1:0]   seed;
        int                  count;
        req_ch.valid          = 1'b0;
        req_ch.channel_offset = '0;
        req_ch.lfsr_seed      = '0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.data           = '0;
        typed_pending         = 1'b0;
        typed_hop             = NO_HOP;
        mismatches            = 0;
        hops_seen             = 0;
        send_streak           = 0;
        send_quiet            = 1'b0;
        take_streak           = 0;
        take_quiet            = 1'b0;
        max_channel_now       = MAX_CH_RST;
        i_rst_n               = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table under the reset max_channel
        for (int r = 0; r < NUM_ROWS; r++) begin
            send_request(DIRECTED_ROWS[r].offset, DIRECTED_ROWS[r].seed,
                         DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].want);
        end
        drain_hops();

        // random requests over a sweep of max_channel settings
        for (int p = 0; p < NUM_PHASES; p++) begin
            max_ch = (p < NUM_FIXED) ? MAX_CH_PLAN[p] : CHAN_W'($urandom_range(63, 126));
            write_max_channel(max_ch);
            count = (max_ch < 7'd20) ? 25 : 60;
            for (int i = 0; i < count; i++) begin
                case ($urandom_range(0, 15))
                    0:       seed = ZERO_SEED;
                    1:       seed = DEAD_SEED;
                    default: seed = SEED_W'($urandom_range(1, 255));
                endcase
                if ($urandom_range(0, 7) == 0) begin
                    offset = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                end else begin
                    offset = OFFSET_W'($urandom_range(0, 255));
                end
                send_request(offset, seed, 1'b0, NO_HOP);
            end
            drain_hops();
        end

        if (mismatches == 0 && expected_hops.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
